// ----- rtl/itel_pkg.sv -----
// ----------------------------------------------------------------------------
// itel_pkg
// Types and constants shared by the impact threshold event log modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itel_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_RECORDED = 3'd0;
    localparam logic [2:0] KIND_BELOW    = 3'd1;
    localparam logic [2:0] KIND_DROPPED  = 3'd2;
    localparam logic [2:0] KIND_ENTRY    = 3'd3;
    localparam logic [2:0] KIND_EMPTY    = 3'd4;

    // Request opcodes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // 17 m/s^2 in units of 1/256 m/s^2.
    localparam logic [15:0] THRESHOLD_RESET = 16'd4352;

    localparam int PEND_W      = 7;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [63:0]        sample_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         result_kind;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [63:0]        out_time;
        logic [PEND_W-1:0]  pending_count;
        logic               last_result;
    } t_out_item;

    // One stored log entry.
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [63:0]        sample_time;
    } t_entry;

    // Classified request handed from the front end to the log controller.
    typedef struct packed {
        logic   is_drain;
        logic   above;
        t_entry entry;
    } t_cmd;

    typedef struct packed {
        logic              busy;
        logic [PEND_W-1:0] count;
    } t_back_status;

endpackage

`default_nettype wire

// ----- rtl/itel_front.sv -----
// ----------------------------------------------------------------------------
// itel_front
// Accepts requests, squares a sample's axes and the threshold, compares the
// squared magnitude against the squared threshold and queues the classified request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itel_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire itel_pkg::t_in_item i_in_item,
    output logic                  o_in_stall,
    input  wire logic [15:0]      i_threshold,
    output logic                  o_push_valid,
    output itel_pkg::t_cmd        o_push_cmd,
    input  wire logic             i_q_full
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_SQR  = 3'b010,
        F_CMP  = 3'b100
    } t_front_state;

    t_front_state       r_state;
    t_front_state       n_state;
    itel_pkg::t_in_item r_item;
    logic [31:0]        r_sq_x;
    logic [31:0]        r_sq_y;
    logic [31:0]        r_sq_z;
    logic [31:0]        r_thr_sq;
    logic signed [31:0] w_px;
    logic signed [31:0] w_py;
    logic signed [31:0] w_pz;
    logic [31:0]        w_pt;
    logic [31:0]        w_mag_sq;

    assign w_px = 32'(r_item.accel_x) * 32'(r_item.accel_x);
    assign w_py = 32'(r_item.accel_y) * 32'(r_item.accel_y);
    assign w_pz = 32'(r_item.accel_z) * 32'(r_item.accel_z);
    assign w_pt = 32'(i_threshold) * 32'(i_threshold);

    // Three squares of 16-bit values stay below 2^32.
    assign w_mag_sq = r_sq_x + r_sq_y + r_sq_z;

    assign o_in_stall = (r_state != F_IDLE);

    always_comb begin
        n_state      = r_state;
        o_push_valid = 1'b0;
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_in_item.opcode == itel_pkg::OP_DRAIN) ? F_CMP : F_SQR;
                end
            end
            F_SQR: begin
                n_state = F_CMP;
            end
            F_CMP: begin
                if (!i_q_full) begin
                    o_push_valid = 1'b1;
                    n_state      = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_comb begin
        o_push_cmd.is_drain          = (r_item.opcode == itel_pkg::OP_DRAIN);
        o_push_cmd.above             = (w_mag_sq > r_thr_sq);
        o_push_cmd.entry.accel_x     = r_item.accel_x;
        o_push_cmd.entry.accel_y     = r_item.accel_y;
        o_push_cmd.entry.accel_z     = r_item.accel_z;
        o_push_cmd.entry.sample_time = r_item.sample_time;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_in_valid) begin
            r_item <= i_in_item;
        end
        if (r_state == F_SQR) begin
            r_sq_x   <= $unsigned(w_px);
            r_sq_y   <= $unsigned(w_py);
            r_sq_z   <= $unsigned(w_pz);
            r_thr_sq <= w_pt;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/itel_fifo.sv -----
// ----------------------------------------------------------------------------
// itel_fifo
// Short request queue between the front end and the log controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itel_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire itel_pkg::t_cmd i_push_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output itel_pkg::t_cmd      o_head,
    output logic                o_empty
);

    localparam int QAW = (itel_pkg::QUEUE_DEPTH > 1) ? $clog2(itel_pkg::QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(itel_pkg::QUEUE_DEPTH + 1);

    itel_pkg::t_cmd r_slot [itel_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_fill;
    logic           w_do_push;
    logic           w_do_pop;

    assign o_full    = (r_fill == QCW'(itel_pkg::QUEUE_DEPTH));
    assign o_empty   = (r_fill == '0);
    assign o_head    = r_slot[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAW'(itel_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(itel_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                         : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/itel_back.sv -----
// ----------------------------------------------------------------------------
// itel_back
// Log controller: appends recorded impacts to the log memory, drains it one
// entry per cycle unless stalled and drives the registered result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itel_back #(
    parameter int LOG_DEPTH = 64
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_empty,
    input  wire itel_pkg::t_cmd i_q_head,
    output logic                o_pop,
    output logic                o_out_valid,
    output itel_pkg::t_out_item o_out_item,
    input  wire logic           i_out_stall,
    output itel_pkg::t_back_status o_status
);

    localparam int AW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CW = $clog2(LOG_DEPTH + 1);

    typedef enum logic [1:0] {
        B_IDLE  = 2'b01,
        B_DRAIN = 2'b10
    } t_back_state;

    t_back_state         r_state;
    t_back_state         n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic [AW-1:0]       r_idx;
    logic [AW-1:0]       n_idx;
    logic                r_out_valid;
    logic                n_out_valid;
    itel_pkg::t_out_item r_out_item;
    itel_pkg::t_out_item n_out_item;
    itel_pkg::t_entry    r_log_mem [LOG_DEPTH];
    itel_pkg::t_entry    r_rd_data;
    logic                w_load_ok;
    logic                w_full;
    logic                w_last;
    logic                w_we;
    logic                w_rd_en;
    logic [AW-1:0]       w_rd_addr;

    assign w_load_ok = !r_out_valid || !i_out_stall;
    assign w_full    = (r_count == CW'(LOG_DEPTH));
    assign w_last    = ((CW'(r_idx) + 1'b1) == r_count);

    assign o_out_valid    = r_out_valid;
    assign o_out_item     = r_out_item;
    assign o_status.busy  = (r_state == B_DRAIN);
    assign o_status.count = itel_pkg::PEND_W'(r_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_item  = r_out_item;
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = '0;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    if (!i_q_head.is_drain) begin
                        if (w_load_ok) begin
                            o_pop       = 1'b1;
                            n_out_valid = 1'b1;
                            if (!i_q_head.above) begin
                                n_out_item.result_kind = itel_pkg::KIND_BELOW;
                            end else if (w_full) begin
                                n_out_item.result_kind = itel_pkg::KIND_DROPPED;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + 1'b1;
                                n_out_item.result_kind = itel_pkg::KIND_RECORDED;
                            end
                            n_out_item.out_x         = '0;
                            n_out_item.out_y         = '0;
                            n_out_item.out_z         = '0;
                            n_out_item.out_time      = '0;
                            n_out_item.pending_count = itel_pkg::PEND_W'(n_count);
                            n_out_item.last_result   = 1'b1;
                        end
                    end else if (r_count == '0) begin
                        if (w_load_ok) begin
                            o_pop       = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_item.result_kind   = itel_pkg::KIND_EMPTY;
                            n_out_item.out_x         = '0;
                            n_out_item.out_y         = '0;
                            n_out_item.out_z         = '0;
                            n_out_item.out_time      = '0;
                            n_out_item.pending_count = '0;
                            n_out_item.last_result   = 1'b1;
                        end
                    end else begin
                        // Fetch the oldest entry; results follow one per cycle unless stalled.
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_idx     = '0;
                        n_state   = B_DRAIN;
                    end
                end
            end
            B_DRAIN: begin
                if (w_load_ok) begin
                    n_out_valid = 1'b1;
                    n_out_item.result_kind   = itel_pkg::KIND_ENTRY;
                    n_out_item.out_x         = r_rd_data.accel_x;
                    n_out_item.out_y         = r_rd_data.accel_y;
                    n_out_item.out_z         = r_rd_data.accel_z;
                    n_out_item.out_time      = r_rd_data.sample_time;
                    n_out_item.pending_count = '0;
                    n_out_item.last_result   = w_last;
                    if (w_last) begin
                        o_pop   = 1'b1;
                        n_count = '0;
                        n_state = B_IDLE;
                    end else begin
                        n_idx     = r_idx + 1'b1;
                        w_rd_en   = 1'b1;
                        w_rd_addr = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_log_mem[r_count[AW-1:0]] <= i_q_head.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_log_mem[w_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/impact_threshold_event_log.sv -----
// ----------------------------------------------------------------------------
// impact_threshold_event_log
// Compares the magnitude of acceleration samples against a threshold, logs
// the impacts with their timestamps and drains the log on request.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Payload
//   in        input      i_in_valid / o_in_stall   itel_pkg::t_in_item
//   out       output     o_out_valid / i_out_stall itel_pkg::t_out_item
//   cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (threshold)
//
// The front end takes one request at a time: a sample passes capture, square
// and compare, a drain capture and compare, as long as the queue has room.
// A sample result then passes the queue and is registered on the result port.
// A drain reads the first entry, then one result per cycle unless stalled.
// A two-entry queue lets the front end keep working while results stall.
// Reset is synchronous and empties the log; log memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module impact_threshold_event_log #(
    parameter int LOG_DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire itel_pkg::t_in_item  i_in_item,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output itel_pkg::t_out_item      o_out_item,
    input  wire logic                i_out_stall,
    input  wire logic                i_cfg_valid,
    input  wire logic [15:0]         i_cfg_data,
    output logic                     o_cfg_ready
);

    logic [15:0]            r_threshold;
    logic                   w_push_valid;
    itel_pkg::t_cmd         w_push_cmd;
    logic                   w_q_full;
    logic                   w_q_empty;
    itel_pkg::t_cmd         w_q_head;
    logic                   w_pop;
    itel_pkg::t_back_status w_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= itel_pkg::THRESHOLD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    itel_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_threshold  (r_threshold),
        .o_push_valid (w_push_valid),
        .o_push_cmd   (w_push_cmd),
        .i_q_full     (w_q_full)
    );

    itel_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push_valid),
        .i_push_cmd (w_push_cmd),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_head     (w_q_head),
        .o_empty    (w_q_empty)
    );

    itel_back #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_head    (w_q_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .o_status    (w_status)
    );

    // The front end must never push into a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push_valid && w_q_full))
        else $error("request pushed into a full queue");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= itel_pkg::PEND_W'(LOG_DEPTH))
        else $error("log count above depth");

    a_drain_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.busy |-> (w_status.count != '0))
        else $error("drain running on an empty log");

    // While the final entry of a drain is taken, the log is already empty.
    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_item.last_result
         && o_out_item.result_kind == itel_pkg::KIND_ENTRY)
        |-> (w_status.count == '0))
        else $error("log not empty after drain");

endmodule

`default_nettype wire
